// ===== rtl/date_offset_adder_defines.svh =====
// Assertion helpers shared by the date offset adder RTL.
// Both expect signals clk and rst in the enclosing scope.
`ifndef DATE_OFFSET_ADDER_DEFINES_SVH
`define DATE_OFFSET_ADDER_DEFINES_SVH

// Same-cycle implication.
`define DOA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/doa_pkg.sv =====
package doa_pkg;

  localparam int StepW = 3;
  typedef logic [StepW-1:0] step_t;

  localparam logic [16:0] SPAN_DAYS  = 17'd73049;
  localparam logic [11:0] FIRST_YEAR = 12'd1900;
  localparam logic [11:0] LAST_YEAR  = 12'd2099;
  localparam logic [3:0]  LAST_MONTH = 4'd12;

  // config register indexes
  localparam logic [1:0] REG_YEAR  = 2'd0;
  localparam logic [1:0] REG_MONTH = 2'd1;
  localparam logic [1:0] REG_DAY   = 2'd2;

  localparam logic [11:0] RST_YEAR  = 12'd2000;
  localparam logic [3:0]  RST_MONTH = 4'd1;
  localparam logic [4:0]  RST_DAY   = 5'd1;

  // datapath operations
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_YFWD  = 3'd2,
    OP_MFWD  = 3'd3,
    OP_WRAP  = 3'd4,
    OP_YBACK = 3'd5,
    OP_MBACK = 3'd6,
    OP_EMIT  = 3'd7
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_NO_ITEM  = 3'd1,
    C_CNT_LT_Y = 3'd2,
    C_CNT_LT_M = 3'd3,
    C_OUT_SPAN = 3'd4,
    C_YBACK    = 3'd5,
    C_MBACK    = 3'd6,
    C_OUT_BUSY = 3'd7
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic item;
    logic cnt_lt_y;
    logic cnt_lt_m;
    logic out_span;
    logic yback;
    logic mback;
    logic out_busy;
  } flags_t;

  // Valid for 1900..2099 only: 1900 is the one century year in range that is not leap.
  function automatic logic is_leap(logic [11:0] y);
    return (y[1:0] == 2'd0) && (y != FIRST_YEAR);
  endfunction

  function automatic logic [4:0] month_len(logic [11:0] y, logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = is_leap(y) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] year_len(logic [11:0] y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

  // Microcode program: on a taken condition jump to target, else step + 1.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      3'd0:    w = '{op: OP_IDLE,  cond: C_NO_ITEM,  target: 3'd0};
      3'd1:    w = '{op: OP_LOAD,  cond: C_NEVER,    target: 3'd0};
      3'd2:    w = '{op: OP_YFWD,  cond: C_CNT_LT_Y, target: 3'd2};
      3'd3:    w = '{op: OP_MFWD,  cond: C_CNT_LT_M, target: 3'd3};
      3'd4:    w = '{op: OP_WRAP,  cond: C_OUT_SPAN, target: 3'd4};
      3'd5:    w = '{op: OP_YBACK, cond: C_YBACK,    target: 3'd5};
      3'd6:    w = '{op: OP_MBACK, cond: C_MBACK,    target: 3'd6};
      default: w = '{op: OP_EMIT,  cond: C_OUT_BUSY, target: 3'd7};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/doa_seq.sv =====
`include "date_offset_adder_defines.svh"

module doa_seq (
  input  logic            clk,
  input  logic            rst,
  input  doa_pkg::flags_t flags,
  output doa_pkg::uword_t uw
);

  doa_pkg::step_t step;
  doa_pkg::step_t step_next;
  logic           hit;

  assign uw = doa_pkg::ucode(step);

  always_comb begin
    unique case (uw.cond)
      doa_pkg::C_NEVER:    hit = 1'b0;
      doa_pkg::C_NO_ITEM:  hit = !flags.item;
      doa_pkg::C_CNT_LT_Y: hit = flags.cnt_lt_y;
      doa_pkg::C_CNT_LT_M: hit = flags.cnt_lt_m;
      doa_pkg::C_OUT_SPAN: hit = flags.out_span;
      doa_pkg::C_YBACK:    hit = flags.yback;
      doa_pkg::C_MBACK:    hit = flags.mback;
      doa_pkg::C_OUT_BUSY: hit = flags.out_busy;
      default:             hit = 1'b0;
    endcase
    step_next = hit ? uw.target : step + doa_pkg::step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  `DOA_ASSERT_NEXT(a_item_starts_load, flags.item, uw.op == doa_pkg::OP_LOAD, "item did not start program")
  `DOA_ASSERT_NOW(a_item_only_idle, flags.item, uw.op == doa_pkg::OP_IDLE, "item taken mid program")

endmodule

// ===== rtl/doa_dp.sv =====
`include "date_offset_adder_defines.svh"

module doa_dp (
  input  logic               clk,
  input  logic               rst,
  input  doa_pkg::uword_t    uw,
  output doa_pkg::flags_t    flags,
  input  logic [11:0]        dflt_year,
  input  logic [3:0]         dflt_month,
  input  logic [4:0]         dflt_day,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic signed [17:0] delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               input_valid,
  output logic [16:0]        day_number,
  output logic [11:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out
);

  localparam logic signed [18:0] SpanS = $signed({2'b00, doa_pkg::SPAN_DAYS});

  // captured transaction
  logic [11:0]        yi;
  logic [3:0]         mi;
  logic [4:0]         di;
  logic signed [17:0] dlt;

  // working registers
  logic               vld;
  logic [11:0]        y;
  logic [3:0]         m;
  logic [11:0]        cnt;
  logic signed [18:0] acc;
  logic [16:0]        n;

  logic               accept;
  logic               in_ok;
  logic [11:0]        sel_y;
  logic [3:0]         sel_m;
  logic [4:0]         sel_d;
  logic [4:0]         dlen;
  logic signed [18:0] ylen;
  logic signed [18:0] mlen_fwd;
  logic signed [18:0] mlen_back;

  assign in_stall = (uw.op != doa_pkg::OP_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_ok = (yi >= doa_pkg::FIRST_YEAR) && (yi <= doa_pkg::LAST_YEAR) &&
            (mi >= 4'd1) && (mi <= doa_pkg::LAST_MONTH) &&
            (di >= 5'd1) && (di <= doa_pkg::month_len(yi, mi));
    // default date, saturated into range
    if (dflt_year < doa_pkg::FIRST_YEAR) begin
      sel_y = doa_pkg::FIRST_YEAR;
    end else if (dflt_year > doa_pkg::LAST_YEAR) begin
      sel_y = doa_pkg::LAST_YEAR;
    end else begin
      sel_y = dflt_year;
    end
    if (dflt_month < 4'd1) begin
      sel_m = 4'd1;
    end else if (dflt_month > doa_pkg::LAST_MONTH) begin
      sel_m = doa_pkg::LAST_MONTH;
    end else begin
      sel_m = dflt_month;
    end
    dlen = doa_pkg::month_len(sel_y, sel_m);
    if (dflt_day < 5'd1) begin
      sel_d = 5'd1;
    end else if (dflt_day > dlen) begin
      sel_d = dlen;
    end else begin
      sel_d = dflt_day;
    end
    if (in_ok) begin
      sel_y = yi;
      sel_m = mi;
      sel_d = di;
    end
  end

  assign ylen      = $signed({10'b0, doa_pkg::year_len(cnt)});
  assign mlen_fwd  = $signed({14'b0, doa_pkg::month_len(y, cnt[3:0])});
  assign mlen_back = mlen_fwd;

  always_comb begin
    flags.item     = accept;
    flags.cnt_lt_y = cnt < y;
    flags.cnt_lt_m = cnt < {8'b0, m};
    flags.out_span = acc[18] || (acc >= SpanS);
    flags.yback    = (cnt < doa_pkg::LAST_YEAR) && (acc >= ylen);
    flags.mback    = (cnt < {8'b0, doa_pkg::LAST_MONTH}) && (acc >= mlen_back);
    flags.out_busy = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      yi  <= year_in;
      mi  <= month_in;
      di  <= day_in;
      dlt <= delta;
    end
    case (uw.op)
      doa_pkg::OP_LOAD: begin
        vld <= in_ok;
        y   <= sel_y;
        m   <= sel_m;
        acc <= $signed({14'b0, sel_d}) - 19'sd1;
        cnt <= doa_pkg::FIRST_YEAR;
      end
      doa_pkg::OP_YFWD: begin
        if (flags.cnt_lt_y) begin
          acc <= acc + ylen;
          cnt <= cnt + 12'd1;
        end else begin
          cnt <= 12'd1;
        end
      end
      doa_pkg::OP_MFWD: begin
        if (flags.cnt_lt_m) begin
          acc <= acc + mlen_fwd;
          cnt <= cnt + 12'd1;
        end else begin
          n   <= acc[16:0];
          acc <= acc + 19'(dlt);
        end
      end
      doa_pkg::OP_WRAP: begin
        if (acc[18]) begin
          acc <= acc + SpanS;
        end else if (acc >= SpanS) begin
          acc <= acc - SpanS;
        end else begin
          cnt <= doa_pkg::FIRST_YEAR;
        end
      end
      doa_pkg::OP_YBACK: begin
        if (flags.yback) begin
          acc <= acc - ylen;
          cnt <= cnt + 12'd1;
        end else begin
          y   <= cnt;
          cnt <= 12'd1;
        end
      end
      doa_pkg::OP_MBACK: begin
        if (flags.mback) begin
          acc <= acc - mlen_back;
          cnt <= cnt + 12'd1;
        end
      end
      default: begin
      end
    endcase
    if (uw.op == doa_pkg::OP_EMIT && !flags.out_busy) begin
      input_valid <= vld;
      day_number  <= n;
      year_out    <= y;
      month_out   <= cnt[3:0];
      day_out     <= acc[4:0] + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uw.op == doa_pkg::OP_EMIT && !flags.out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `DOA_ASSERT_NOW(a_wrap_done_in_span, uw.op == doa_pkg::OP_YBACK, !acc[18] && acc < SpanS, "sum not wrapped")
  `DOA_ASSERT_NEXT(a_emit_month_ok, uw.op == doa_pkg::OP_EMIT && !flags.out_busy, month_out >= 4'd1 && month_out <= doa_pkg::LAST_MONTH, "bad result month")
  `DOA_ASSERT_NOW(a_busy_while_full, uw.op == doa_pkg::OP_EMIT && out_valid && out_stall, flags.out_busy, "result overwritten")

endmodule

// ===== rtl/date_offset_adder.sv =====
// Date offset adder: adds a signed day delta to a Gregorian date (1900..2099).
// Input channel: in_valid / in_stall with year_in, month_in, day_in, delta.
//   A transaction is taken when in_valid is high and in_stall is low. An
//   invalid date is replaced by the default date held in the config registers.
// Output channel: out_valid / out_stall with input_valid, day_number and the
//   resulting year_out, month_out, day_out. One result per input transaction.
// Config channel: cfg_valid / cfg_ready with cfg_index (0 year, 1 month,
//   2 day) and cfg_data; cfg_ready is always high, index 3 is ignored.
// Timing: a microcoded sequencer walks years and months one per cycle through
//   one accumulator: up from 1900 to the checked date, adds delta, wraps the
//   sum into the span, then walks it back out into year_out and month_out; the
//   year walks dominate. An item is taken only while the sequencer is idle.
// Stall: a finished result sits in the output register while the next item
//   is taken and worked; if that item finishes while out_stall still holds,
//   the sequencer waits at its last step and in_stall stays high.
// Reset (rst, synchronous): sequencer to idle, output empty, defaults return
//   to 2000-01-01.
module date_offset_adder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic signed [17:0] delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               input_valid,
  output logic [16:0]        day_number,
  output logic [11:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);

  // default date registers
  logic [11:0] default_year;
  logic [3:0]  default_month;
  logic [4:0]  default_day;

  doa_pkg::uword_t uw;
  doa_pkg::flags_t flags;

  assign cfg_ready = 1'b1;

  // Config writes: user must make them only while idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      default_year  <= doa_pkg::RST_YEAR;
      default_month <= doa_pkg::RST_MONTH;
      default_day   <= doa_pkg::RST_DAY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        doa_pkg::REG_YEAR:  default_year  <= cfg_data;
        doa_pkg::REG_MONTH: default_month <= cfg_data[3:0];
        doa_pkg::REG_DAY:   default_day   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // step counter + microcode ROM
  doa_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uw    (uw)
  );

  // accumulator, counter, date registers and output register
  doa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .uw          (uw),
    .flags       (flags),
    .dflt_year   (default_year),
    .dflt_month  (default_month),
    .dflt_day    (default_day),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .year_in     (year_in),
    .month_in    (month_in),
    .day_in      (day_in),
    .delta       (delta),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .input_valid (input_valid),
    .day_number  (day_number),
    .year_out    (year_out),
    .month_out   (month_out),
    .day_out     (day_out)
  );

endmodule

// ===== tb/date_checker.sv =====
`timescale 1ns / 1ps

// Watches the input, output and config channels of date_offset_adder.
// Keeps its own copy of the default date, predicts each result when the
// input transaction is taken and compares it field by field when the
// output transaction is taken.
module date_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [11:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic signed [17:0] delta,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               input_valid,
  input  logic [16:0]        day_number,
  input  logic [11:0]        year_out,
  input  logic [3:0]         month_out,
  input  logic [4:0]         day_out,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  output int                 outstanding,
  output int                 failures,
  output int                 compared
);

  localparam int SpanDays  = 73049;
  localparam int FirstYear = 1900;
  localparam int LastYear  = 2099;

  typedef struct packed {
    logic        ok;
    logic [16:0] days;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } dated_result_t;

  logic [11:0] dflt_year;
  logic [3:0]  dflt_month;
  logic [4:0]  dflt_day;

  dated_result_t due_dates[$];
  dated_result_t want;

  function automatic bit leap_year(int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int days_in_month(int y, int m);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  function automatic int days_in_year(int y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int days_since_epoch(int y, int m, int d);
    int n;
    n = d - 1;
    for (int i = FirstYear; i < y; i++) n += days_in_year(i);
    for (int i = 1; i < m; i++) n += days_in_month(y, i);
    return n;
  endfunction

  function automatic void date_from_days(int n, output int y, output int m, output int d);
    y = FirstYear;
    m = 1;
    while (y < LastYear && n >= days_in_year(y)) begin
      n -= days_in_year(y);
      y++;
    end
    while (m < 12 && n >= days_in_month(y, m)) begin
      n -= days_in_month(y, m);
      m++;
    end
    d = n + 1;
  endfunction

  function automatic dated_result_t predict_offset_date(logic [11:0] y_in, logic [3:0] m_in,
                                                         logic [4:0] d_in,
                                                         logic signed [17:0] dl);
    dated_result_t r;
    int y, m, d, n, sum, ry, rm, rd;
    bit ok;
    y = y_in;
    m = m_in;
    d = d_in;
    ok = y >= FirstYear && y <= LastYear && m >= 1 && m <= 12 &&
         d >= 1 && d <= days_in_month(y, m);
    if (!ok) begin
      // default date, forced into range before use
      y = dflt_year;
      if (y < FirstYear) y = FirstYear;
      if (y > LastYear) y = LastYear;
      m = dflt_month;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      d = dflt_day;
      if (d < 1) d = 1;
      if (d > days_in_month(y, m)) d = days_in_month(y, m);
    end
    n = days_since_epoch(y, m, d);
    sum = (n + int'(dl)) % SpanDays;
    if (sum < 0) sum += SpanDays;
    date_from_days(sum, ry, rm, rd);
    r.ok    = ok;
    r.days  = n[16:0];
    r.year  = ry[11:0];
    r.month = rm[3:0];
    r.day   = rd[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    failures++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dflt_year  = doa_pkg::RST_YEAR;
      dflt_month = doa_pkg::RST_MONTH;
      dflt_day   = doa_pkg::RST_DAY;
      failures   = 0;
      compared   = 0;
      due_dates.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          doa_pkg::REG_YEAR:  dflt_year  = cfg_data;
          doa_pkg::REG_MONTH: dflt_month = cfg_data[3:0];
          doa_pkg::REG_DAY:   dflt_day   = cfg_data[4:0];
          default:   ;
        endcase
      end
      if (in_valid && !in_stall)
        due_dates.push_back(predict_offset_date(year_in, month_in, day_in, delta));
      if (out_valid && !out_stall) begin
        if (due_dates.size() == 0) begin
          report_mismatch("result transaction with no prediction pending");
        end else begin
          want = due_dates.pop_front();
          if (input_valid !== want.ok)
            report_mismatch($sformatf("input_valid exp %0d got %0d", want.ok, input_valid));
          if (day_number !== want.days)
            report_mismatch($sformatf("day_number exp %0d got %0d", want.days, day_number));
          if (year_out !== want.year)
            report_mismatch($sformatf("year_out exp %0d got %0d", want.year, year_out));
          if (month_out !== want.month)
            report_mismatch($sformatf("month_out exp %0d got %0d", want.month, month_out));
          if (day_out !== want.day)
            report_mismatch($sformatf("day_out exp %0d got %0d", want.day, day_out));
          compared++;
        end
      end
    end
    outstanding <= due_dates.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Top of the date_offset_adder bench: clock, reset, stimulus and verdict.
// All checking lives in date_checker, which sits beside the block.
module tb;

  localparam int NumPhases    = 10;
  localparam int RandPerPhase = 193;
  // cycles to let the sequencer fall back to idle after the last result
  localparam int SettleCycles = 16;
  localparam logic [1:0] REG_SPARE = 2'd3;  // unused index, write must be ignored

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [11:0]        year_in;
  logic [3:0]         month_in;
  logic [4:0]         day_in;
  logic signed [17:0] delta;
  logic               out_valid;
  logic               out_stall;
  logic               input_valid;
  logic [16:0]        day_number;
  logic [11:0]        year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [11:0]        cfg_data;

  int outstanding;
  int failures;
  int compared;
  int items_sent;
  int phase;
  int stall_left;
  bit calm;  // set for the closing stretch: no gaps on either side

  date_offset_adder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .year_in    (year_in),
    .month_in   (month_in),
    .day_in     (day_in),
    .delta      (delta),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .input_valid(input_valid),
    .day_number (day_number),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  date_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .year_in    (year_in),
    .month_in   (month_in),
    .day_in     (day_in),
    .delta      (delta),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .input_valid(input_valid),
    .day_number (day_number),
    .year_out   (year_out),
    .month_out  (month_out),
    .day_out    (day_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .failures   (failures),
    .compared   (compared)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Output back-pressure: bursts of random length, each stalled or not at random,
  // stalled about a third of the time. Quiet once the closing stretch starts.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(0, 12);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog. It sits several times beyond the worst case: the longest
  // transactions plus both sides' longest gaps.
  initial begin
    #20_000_000;
    $display("date_offset_adder test failed");
    $finish;
  end

  // One input transaction. Valid stays up between back-to-back transactions;
  // apart from settle(), it only drops for a random gap, entered right after an
  // acceptance or with valid low, so valid never sees two updates in one step.
  task automatic send_item(input logic [11:0] y, input logic [3:0] m, input logic [4:0] d,
                           input logic signed [17:0] dl);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    year_in  <= y;
    month_in <= m;
    day_in   <= d;
    delta    <= dl;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid, wait until every prediction has been matched, then give the
  // sequencer time to return to idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Config writes go back to back; valid is lowered once, after the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_defaults(input logic [11:0] y, input logic [11:0] m,
                               input logic [11:0] d);
    write_reg(doa_pkg::REG_YEAR, y);
    write_reg(doa_pkg::REG_MONTH, m);
    write_reg(doa_pkg::REG_DAY, d);
    write_reg(REG_SPARE, 12'($urandom));  // must not disturb anything
    cfg_valid <= 1'b0;
  endtask

  // Random transaction. Mostly well-formed dates so the year and month walks
  // get real work; the rest sits on calendar edges or is raw noise.
  task automatic next_random_item();
    int kind, y, m, d, dsel;
    logic signed [17:0] dl;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      y = $urandom_range(1900, 2099);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, doa_pkg::month_len(12'(y), 4'(m)));
    end else if (kind < 85) begin
      // around year boundaries, month ends and leap days
      y = ($urandom_range(0, 1) == 0) ? $urandom_range(1898, 1902) : $urandom_range(2097, 2101);
      m = $urandom_range(0, 13);
      d = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(27, 31);
    end else begin
      y = $urandom_range(0, 4095);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end
    dsel = $urandom_range(0, 9);
    if (dsel < 5)
      dl = 18'($urandom);
    else if (dsel < 8)
      dl = 18'($urandom_range(0, 800) - 400);
    else if (dsel == 8)
      dl = ($urandom_range(0, 1) == 0) ? 18'sh1FFFF : 18'sh20000;
    else
      // near one full span either way, lands close to the start date
      dl = 18'($urandom_range(73039, 73059) * (($urandom_range(0, 1) == 0) ? 1 : -1));
    send_item(12'(y), 4'(m), 5'(d), dl);
  endtask

  initial begin
    rst        = 1'b1;
    calm       = 1'b0;
    in_valid   = 1'b0;
    year_in    = '0;
    month_in   = '0;
    day_in     = '0;
    delta      = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed set under the reset default (2000-01-01).
    send_item(12'd1900, 4'd1,  5'd1,  18'sd0);       // first day of the span
    send_item(12'd2099, 4'd12, 5'd31, 18'sd0);       // last day of the span
    send_item(12'd1900, 4'd1,  5'd1,  -18'sd1);      // wraps down to the end
    send_item(12'd2099, 4'd12, 5'd31, 18'sd1);       // wraps up to the start
    send_item(12'd2000, 4'd2,  5'd29, 18'sh1FFFF);   // most positive delta
    send_item(12'd2000, 4'd2,  5'd29, 18'sh20000);   // most negative delta
    send_item(12'd1900, 4'd2,  5'd29, 18'sd5);       // 1900 is not leap
    send_item(12'd2004, 4'd2,  5'd29, 18'sd365);
    send_item(12'd2001, 4'd2,  5'd29, 18'sd0);       // invalid leap day
    send_item(12'd2100, 4'd1,  5'd1,  18'sd10);      // year past range
    send_item(12'd1899, 4'd12, 5'd31, 18'sd10);      // year before range
    send_item(12'd0,    4'd0,  5'd0,  -18'sd1);      // all-zero date
    send_item(12'hFFF,  4'hF,  5'h1F, 18'sh1FFFF);   // all-ones fields
    send_item(12'd2023, 4'd4,  5'd31, 18'sd0);       // day past a 30-day month
    send_item(12'd2023, 4'd4,  5'd30, 18'sd0);
    send_item(12'd2023, 4'd13, 5'd1,  18'sd0);       // month 13
    send_item(12'd2050, 4'd6,  5'd0,  18'sd0);       // day 0
    send_item(12'd2099, 4'd12, 5'd31, -18'sd73049);  // one full span back
    send_item(12'd1900, 4'd1,  5'd1,  18'sd73048);
    send_item(12'd1999, 4'd12, 5'd31, 18'sd1);       // year rollover
    send_item(12'd2000, 4'd3,  5'd1,  -18'sd1);      // back onto Feb 29
    send_item(12'd1900, 4'd3,  5'd1,  -18'sd1);      // back onto Feb 28 1900

    // Phases of default-date settings, including out-of-range defaults that
    // must be clamped. Each phase opens with invalid dates so the new default
    // is really used, then runs random traffic.
    for (phase = 0; phase < NumPhases; phase++) begin
      settle();
      case (phase)
        0:       load_defaults(12'd1900, 12'd1, 12'd1);
        1:       load_defaults(12'd2099, 12'd12, 12'd28);
        2:       load_defaults(12'd0, 12'd0, 12'd0);          // clamps to 1900-01-01
        3:       load_defaults(12'hFFF, 12'hFFF, 12'hFFF);    // clamps to 2099-12-31
        4:       load_defaults(12'd1900, 12'd2, 12'd31);      // Feb 28 1900
        5:       load_defaults(12'd2000, 12'd2, 12'd30);      // Feb 29 2000
        6:       load_defaults(12'd2099, 12'd4, 12'd31);      // Apr 30
        7:       load_defaults(12'($urandom), 12'($urandom), 12'($urandom));
        8:       load_defaults(12'($urandom_range(1900, 2099)), 12'($urandom_range(1, 12)),
                               12'($urandom_range(1, 28)));
        default: load_defaults(doa_pkg::RST_YEAR, 12'(doa_pkg::RST_MONTH),
                               12'(doa_pkg::RST_DAY));
      endcase
      if (phase == NumPhases - 1) calm = 1'b1;
      send_item(12'd0, 4'd0, 5'd0, 18'sd0);
      send_item(12'd2099, 4'd2, 5'd29, 18'sd1);  // 2099 is not leap
      repeat (RandPerPhase) next_random_item();
    end

    settle();
    $display("Covered %0d input transactions across %0d default-date settings,",
             items_sent, NumPhases + 1);
    $display("with %0d results compared field by field.", compared);
    if (failures == 0 && outstanding == 0) begin
      $display("date_offset_adder test passed");
    end else begin
      $display("date_offset_adder test failed");
    end
    $finish;
  end

endmodule
